### hdl/slm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types, codes and constants of the section latency monitor.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int DefNumSections = 4;
  localparam int DefNumSubs     = 6;

  localparam int DIV_W   = 32;
  localparam int TPU_W   = 10;
  localparam int NOVER   = 12;
  localparam int NTALLY  = 9;
  localparam int NSLOW   = 10;

  localparam logic [31:0] SLOW_US    = 32'd16000;
  localparam logic [31:0] DOM_US     = 32'd8000;
  localparam logic [31:0] MINOR_US   = 32'd4000;
  localparam logic [7:0]  NEST_MAX   = 8'd255;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_OPEN    = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;

  typedef enum logic [2:0] {
    REQ_BEG_SEC  = 3'd0,
    REQ_END_SEC  = 3'd1,
    REQ_BEG_SUB  = 3'd2,
    REQ_END_SUB  = 3'd3,
    REQ_READ     = 3'd4,
    REQ_RST_PEAK = 3'd5,
    REQ_RST_CNT  = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_UPD,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    UK_SEC,
    UK_SUB,
    UK_PERIOD
  } upd_e;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [TPU_W-1:0]   divisor;
  } div_req_t;

  // Over-threshold limits per section and level.
  function automatic logic [31:0] limit_of(input logic [1:0] sec, input logic [1:0] lvl);
    logic [31:0] r;
    r = 32'd0;
    case (sec)
      2'd0: begin
        case (lvl)
          2'd0: r = 32'd8000;
          2'd1: r = 32'd16666;
          default: r = 32'd33333;
        endcase
      end
      2'd3: begin
        case (lvl)
          2'd0: r = 32'd16666;
          2'd1: r = 32'd33333;
          default: r = 32'd50000;
        endcase
      end
      default: begin
        case (lvl)
          2'd0: r = 32'd4000;
          2'd1: r = 32'd8000;
          default: r = 32'd16666;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

### hdl/section_latency_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_latency_monitor
// Times code sections and sub-activities from event tick stamps and keeps
// last, peak, total and count statistics plus slow-event records.
// ----------------------------------------------------------------------------
//  Channel  Handshake                  Word
//  in       in_valid_i / in_stall_o    req_type, section, sub_index, event_tick,
//                                      area_px, stat_index
//  out      out_valid_o / out_stall_i  read_data, duration_us, slow_reason,
//                                      slow_captured, status
//  cfg      cfg_wr_en_i                cfg_wr_data_i = ticks_per_us
//
// A word that needs a duration passes from the execute step through the
// shared divider, which produces one quotient bit per cycle, and then an
// update step to its result. Every other word passes from the execute step
// straight to its result. One word is in flight at a time; in_stall_o is
// high until its result is taken. A stalled result holds. Reset clears every
// statistic and sets ticks_per_us to 1.
module section_latency_monitor #(
  parameter int NUM_SECTIONS = slm_pkg::DefNumSections,
  parameter int NUM_SUBS     = slm_pkg::DefNumSubs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [9:0]  cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [1:0]  section_i,
  input  logic [2:0]  sub_index_i,
  input  logic [31:0] event_tick_i,
  input  logic [23:0] area_px_i,
  input  logic [6:0]  stat_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_data_o,
  output logic [31:0] duration_us_o,
  output logic [2:0]  slow_reason_o,
  output logic        slow_captured_o,
  output logic [1:0]  status_o
);
  import slm_pkg::*;

  localparam int NREC   = NUM_SECTIONS + NUM_SUBS + 1;
  localparam int PERIOD = NUM_SECTIONS + NUM_SUBS;
  localparam int REC_W  = $clog2(NREC);
  localparam int SEC_W  = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int SUB_W  = (NUM_SUBS > 1) ? $clog2(NUM_SUBS) : 1;
  localparam int OPeak  = NREC;
  localparam int OTotal = 2 * NREC;
  localparam int OCount = 3 * NREC;
  localparam int OOver  = 4 * NREC;
  localparam int OTally = OOver + NOVER;
  localparam int OSlow  = OTally + NTALLY;
  localparam int OSeq   = OSlow + NSLOW;

  state_e state_q, state_d;

  // Latched word.
  logic [2:0]  req_q;
  logic [1:0]  sec_q;
  logic [2:0]  sub_q;
  logic [31:0] now_q;
  logic [23:0] area_q;
  logic [6:0]  sidx_q;

  logic [TPU_W-1:0] tpu_q;

  logic [31:0] sec_stamp_q [NUM_SECTIONS];
  logic [31:0] sub_stamp_q [NUM_SUBS];
  logic [7:0]  nest_q      [NUM_SUBS];
  logic [31:0] last_q      [NREC];
  logic [31:0] peak_q      [NREC];
  logic [63:0] total_q     [NREC];
  logic [31:0] count_q     [NREC];
  logic [31:0] over_q      [NOVER];
  logic [63:0] tally_q     [NTALLY];
  logic [31:0] slow_q      [NSLOW];
  logic [31:0] prior_q;
  logic [31:0] seq_q;
  logic [2:0]  reason_q;

  logic [REC_W-1:0] rec_q;
  upd_e             kind_q;

  logic [63:0] rdata_q;
  logic [31:0] elapsed_q;
  logic        capt_q;
  logic [1:0]  status_q;

  // Decode of the latched word in the execute step.
  logic             sec_ok, sub_ok;
  logic [SEC_W-1:0] sec_ix;
  logic [SUB_W-1:0] sub_ix;
  logic             ex_div;
  logic [31:0]      ex_diff;
  logic [REC_W-1:0] ex_rec;
  upd_e             ex_kind;
  logic [1:0]       ex_status;
  logic [63:0]      ex_rdata;

  div_req_t    div_req;
  logic        div_done;
  logic [31:0] quot;

  logic [31:0] sub_last [6];
  logic [2:0]  cls;
  logic [31:0] acc_last;

  logic accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign sec_ok = int'(sec_q) < NUM_SECTIONS;
  assign sub_ok = int'(sub_q) < NUM_SUBS;
  assign sec_ix = SEC_W'(sec_q);
  assign sub_ix = SUB_W'(sub_q);

  always_comb begin
    ex_div    = 1'b0;
    ex_diff   = '0;
    ex_rec    = '0;
    ex_kind   = UK_SEC;
    ex_status = STS_DONE;
    case (req_q)
      REQ_BEG_SEC: begin
        if (!sec_ok) begin
          ex_status = STS_IGNORED;
        end else if (sec_q == 2'd3 && prior_q != '0) begin
          ex_div  = 1'b1;
          ex_diff = now_q - prior_q;
          ex_rec  = REC_W'(PERIOD);
          ex_kind = UK_PERIOD;
        end
      end
      REQ_END_SEC: begin
        if (!sec_ok) begin
          ex_status = STS_IGNORED;
        end else begin
          ex_div  = 1'b1;
          ex_diff = now_q - sec_stamp_q[sec_ix];
          ex_rec  = REC_W'(sec_q);
        end
      end
      REQ_BEG_SUB: begin
        if (!sub_ok) begin
          ex_status = STS_IGNORED;
        end
      end
      REQ_END_SUB: begin
        if (!sub_ok || nest_q[sub_ix] == '0) begin
          ex_status = STS_IGNORED;
        end else if (nest_q[sub_ix] != 8'd1) begin
          ex_status = STS_OPEN;
        end else begin
          ex_div  = 1'b1;
          ex_diff = now_q - sub_stamp_q[sub_ix];
          ex_rec  = REC_W'(NUM_SECTIONS + int'(sub_q));
          ex_kind = UK_SUB;
        end
      end
      default: begin
      end
    endcase
  end

  // Dense statistic map.
  always_comb begin
    int si;
    si = int'(sidx_q);
    ex_rdata = '0;
    if (si < OPeak) begin
      ex_rdata = {32'd0, last_q[REC_W'(si)]};
    end else if (si < OTotal) begin
      ex_rdata = {32'd0, peak_q[REC_W'(si - OPeak)]};
    end else if (si < OCount) begin
      ex_rdata = total_q[REC_W'(si - OTotal)];
    end else if (si < OOver) begin
      ex_rdata = {32'd0, count_q[REC_W'(si - OCount)]};
    end else if (si < OTally) begin
      ex_rdata = {32'd0, over_q[4'(si - OOver)]};
    end else if (si < OSlow) begin
      ex_rdata = tally_q[4'(si - OTally)];
    end else if (si < OSeq) begin
      ex_rdata = {32'd0, slow_q[4'(si - OSlow)]};
    end else if (si == OSeq) begin
      ex_rdata = {32'd0, seq_q};
    end else if (si == OSeq + 1) begin
      ex_rdata = {61'd0, reason_q};
    end else if (si == OSeq + 2) begin
      ex_rdata = {32'd0, prior_q};
    end
  end

  assign div_req.start    = (state_q == ST_EXEC) && ex_div;
  assign div_req.dividend = ex_diff;
  assign div_req.divisor  = tpu_q;

  slm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Dominant sub-activity of the main section.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sub_last[k] = (k < NUM_SUBS) ? last_q[REC_W'(NUM_SECTIONS + k)] : '0;
    end
  end

  always_comb begin
    logic [31:0] tm, fl, wt, bl, inp, sc;
    tm = sub_last[0]; fl = sub_last[1]; wt = sub_last[2];
    bl = sub_last[3]; inp = sub_last[4]; sc = sub_last[5];
    if (wt >= fl && wt >= bl && wt >= tm && wt >= inp && wt >= sc && wt > DOM_US) begin
      cls = 3'd3;
    end else if (fl >= bl && fl >= tm && fl >= inp && fl >= sc && fl > DOM_US) begin
      cls = 3'd2;
    end else if (bl >= tm && bl >= inp && bl >= sc && bl > DOM_US) begin
      cls = 3'd4;
    end else if (tm >= inp && tm >= sc && tm > DOM_US) begin
      cls = 3'd1;
    end else if (inp >= sc && inp > MINOR_US) begin
      cls = 3'd5;
    end else if (sc > MINOR_US) begin
      cls = 3'd6;
    end else if (quot > DOM_US) begin
      cls = 3'd7;
    end else begin
      cls = 3'd0;
    end
  end

  assign acc_last = last_q[rec_q] + quot;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:   state_d = ex_div ? ST_DIV : ST_RESULT;
      ST_DIV:    if (div_done) state_d = ST_UPD;
      ST_UPD:    state_d = ST_RESULT;
      ST_RESULT: if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_RESULT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      sec_q  <= section_i;
      sub_q  <= sub_index_i;
      now_q  <= event_tick_i;
      area_q <= area_px_i;
      sidx_q <= stat_index_i;
    end
    if (state_q == ST_EXEC) begin
      rec_q  <= ex_rec;
      kind_q <= ex_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q     <= TPU_W'(1);
      prior_q   <= '0;
      seq_q     <= '0;
      reason_q  <= '0;
      rdata_q   <= '0;
      elapsed_q <= '0;
      capt_q    <= 1'b0;
      status_q  <= STS_DONE;
      for (int i = 0; i < NUM_SECTIONS; i++) sec_stamp_q[i] <= '0;
      for (int i = 0; i < NUM_SUBS; i++) begin
        sub_stamp_q[i] <= '0;
        nest_q[i]      <= '0;
      end
      for (int i = 0; i < NREC; i++) begin
        last_q[i]  <= '0;
        peak_q[i]  <= '0;
        total_q[i] <= '0;
        count_q[i] <= '0;
      end
      for (int i = 0; i < NOVER; i++) over_q[i] <= '0;
      for (int i = 0; i < NTALLY; i++) tally_q[i] <= '0;
      for (int i = 0; i < NSLOW; i++) slow_q[i] <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        tpu_q <= cfg_wr_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            rdata_q   <= '0;
            elapsed_q <= '0;
            capt_q    <= 1'b0;
            status_q  <= STS_DONE;
          end
        end
        ST_EXEC: begin
          status_q <= ex_status;
          case (req_q)
            REQ_BEG_SEC: begin
              if (sec_ok) begin
                if (sec_q == 2'd0) begin
                  for (int k = 0; k < NUM_SUBS; k++) last_q[NUM_SECTIONS + k] <= '0;
                  tally_q[0] <= '0;
                  tally_q[3] <= '0;
                  tally_q[6] <= '0;
                  reason_q   <= '0;
                end
                sec_stamp_q[sec_ix] <= now_q;
                if (sec_q == 2'd3) begin
                  prior_q <= now_q;
                end
              end
            end
            REQ_BEG_SUB: begin
              if (sub_ok) begin
                if (sub_q == 3'd1) begin
                  logic [63:0] c, p;
                  c = tally_q[0] + 64'd1;
                  p = tally_q[3] + {40'd0, area_q};
                  tally_q[0] <= c;
                  tally_q[2] <= tally_q[2] + 64'd1;
                  if (c > tally_q[1]) tally_q[1] <= c;
                  tally_q[3] <= p;
                  tally_q[5] <= tally_q[5] + {40'd0, area_q};
                  if (p > tally_q[4]) tally_q[4] <= p;
                end else if (sub_q == 3'd4) begin
                  logic [63:0] c;
                  c = tally_q[6] + 64'd1;
                  tally_q[6] <= c;
                  tally_q[8] <= tally_q[8] + 64'd1;
                  if (c > tally_q[7]) tally_q[7] <= c;
                end
                if (nest_q[sub_ix] == '0) begin
                  sub_stamp_q[sub_ix] <= now_q;
                end
                if (nest_q[sub_ix] != NEST_MAX) begin
                  nest_q[sub_ix] <= nest_q[sub_ix] + 8'd1;
                end
              end
            end
            REQ_END_SUB: begin
              if (sub_ok && nest_q[sub_ix] != '0) begin
                nest_q[sub_ix] <= nest_q[sub_ix] - 8'd1;
              end
            end
            REQ_READ: begin
              rdata_q <= ex_rdata;
            end
            REQ_RST_PEAK: begin
              for (int k = 0; k < NREC; k++) peak_q[k] <= last_q[k];
              tally_q[1] <= tally_q[0];
              tally_q[4] <= tally_q[3];
              tally_q[7] <= tally_q[6];
            end
            REQ_RST_CNT: begin
              for (int k = 0; k < NOVER; k++) over_q[k] <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_UPD: begin
          total_q[rec_q] <= total_q[rec_q] + {32'd0, quot};
          count_q[rec_q] <= count_q[rec_q] + 32'd1;
          if (kind_q == UK_SUB) begin
            // Sub-activities accumulate into their last value.
            last_q[rec_q] <= acc_last;
            if (acc_last > peak_q[rec_q]) peak_q[rec_q] <= acc_last;
            elapsed_q <= quot;
          end else begin
            last_q[rec_q] <= quot;
            if (quot > peak_q[rec_q]) peak_q[rec_q] <= quot;
          end
          if (kind_q == UK_SEC) begin
            elapsed_q <= quot;
            for (int k = 0; k < 3; k++) begin
              if (quot > limit_of(sec_q, 2'(k))) begin
                over_q[4'(int'(sec_q) * 3 + k)] <= over_q[4'(int'(sec_q) * 3 + k)] + 32'd1;
              end
            end
            if (sec_q == 2'd0) begin
              reason_q <= cls;
              if (quot > SLOW_US) begin
                seq_q     <= seq_q + 32'd1;
                slow_q[0] <= quot;
                for (int k = 0; k < 6; k++) slow_q[1 + k] <= sub_last[k];
                slow_q[7] <= tally_q[0][31:0];
                slow_q[8] <= tally_q[3][31:0];
                slow_q[9] <= {29'd0, cls};
                capt_q    <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign read_data_o     = rdata_q;
  assign duration_us_o   = elapsed_q;
  assign slow_reason_o   = reason_q;
  assign slow_captured_o = capt_q;
  assign status_o        = status_q;

endmodule

### hdl/slm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_div
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module slm_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slm_pkg::div_req_t req_i,
  output logic             done_o,
  output logic [slm_pkg::DIV_W-1:0] quot_o
);
  import slm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DIV_W - 1);

  logic [DIV_W-1:0] q_q;
  logic [TPU_W-1:0] rem_q;
  logic [TPU_W-1:0] dv_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, dz_q;
  logic [TPU_W:0]   shifted, trial;
  logic             ge;

  assign shifted = {rem_q, q_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dv_q};
  assign trial   = shifted - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dz_q   <= 1'b0;
      q_q    <= '0;
      rem_q  <= '0;
      dv_q   <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dz_q   <= (req_i.divisor == '0);
      q_q    <= req_i.dividend;
      rem_q  <= '0;
      dv_q   <= req_i.divisor;
    end else if (busy_q) begin
      q_q   <= {q_q[DIV_W-2:0], ge};
      rem_q <= ge ? trial[TPU_W-1:0] : shifted[TPU_W-1:0];
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dz_q ? '0 : q_q;

endmodule

### hdl/slm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks of the section latency monitor, bound to the top level.
// ----------------------------------------------------------------------------
module slm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] duration_us_o,
  input logic        slow_captured_o,
  input logic [1:0]  status_o
);
  import slm_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only one word is in flight.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in flight");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result waits");

  a_ignored_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_IGNORED |-> duration_us_o == '0 && !slow_captured_o)
    else $error("ignored word produced a measurement");

  a_capture_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slow_captured_o |-> duration_us_o > SLOW_US)
    else $error("slow record captured below the limit");

endmodule

bind section_latency_monitor slm_checker u_slm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .duration_us_o   (duration_us_o),
  .slow_captured_o (slow_captured_o),
  .status_o        (status_o)
);
